/* hdl/plri_pkg.sv */
// Shared types, constants and codes for the piecewise-linear rate interpolator.
package plri_pkg;

    // Table size default and lower bound on entries in use
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int MIN_ENTRIES     = 2;

    // Configuration register
    localparam int             CFG_W     = 5;
    localparam logic [CFG_W-1:0] CNT_RESET = 5'd2;

    // Stream payload widths
    localparam int IDX_IN_W    = 4;
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    // Datapath widths
    localparam int ALU_W   = 66;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int Q_W     = 34;
    localparam int K_W     = 6;

    // Saturation bounds, signed Q16.16
    localparam logic [31:0] RATE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] RATE_MIN = 32'h8000_0000;

    // Item kinds on the input tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BEFORE = 2'd1,
        STAT_SAT    = 2'd2,
        STAT_ZSPAN  = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] tenor;
        logic [31:0] rate;
    } entry_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] rate;
        status_t     status;
    } result_t;

endpackage

/* hdl/plri_tbl.sv */
// Breakpoint table: one write port, one registered read port.
module plri_tbl
    import plri_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ENTRIES,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/plri_alu.sv */
// Shared arithmetic unit: one wide adder/subtractor and a 33x16 multiplier.
module plri_alu
    import plri_pkg::*;
(
    input  alu_req_t             req,
    input  logic [MUL_A_W-1:0]   mul_a,
    input  logic [MUL_B_W-1:0]   mul_b,
    output logic [ALU_W-1:0]     sum,
    output logic [MUL_P_W-1:0]   prod
);

    // add or subtract; the sign bit of a difference doubles as a compare
    assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);

    // one partial product per use, registered by the sequencer
    assign prod = mul_a * mul_b;

endmodule

/* hdl/plri_seq.sv */
// Sequencer: table scan, span and slope set-up, product, rounding divide, saturation.
module plri_seq
    import plri_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int AW         = $clog2(MAX_ENTRIES)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  logic               in_cmd,
    input  logic [IDX_IN_W-1:0] in_entry_index,
    input  logic [31:0]        in_tenor,
    input  logic [31:0]        in_rate,
    input  logic [31:0]        in_query_time,
    input  logic [CFG_W-1:0]   entry_count,
    output logic               tbl_wr_en,
    output logic [AW-1:0]      tbl_wr_addr,
    output entry_t             tbl_wr_data,
    output logic [AW-1:0]      tbl_rd_addr,
    input  entry_t             tbl_rd_data,
    output alu_req_t           alu_req,
    output logic [MUL_A_W-1:0] mul_a,
    output logic [MUL_B_W-1:0] mul_b,
    input  logic [ALU_W-1:0]   alu_sum,
    input  logic [MUL_P_W-1:0] mul_p,
    output logic               idle,
    output logic               res_valid,
    output result_t            res,
    input  logic               res_take
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SPAN, S_MSP, S_DT, S_DR, S_MDR, S_MUL_LO,
        S_MUL_HI, S_ACC, S_NUM, S_OVF, S_DIV, S_FIN, S_DONE
    } state_t;

    // control
    state_t            state_reg, state_next;
    result_t           res_reg, res_next;
    logic [AW-1:0]     scan_addr_reg, scan_addr_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [K_W-1:0]    k_reg, k_next;

    // datapath
    logic [31:0]       t_reg, t_next;
    logic [31:0]       t1_reg, t1_next;
    logic [31:0]       r1_reg, r1_next;
    logic [31:0]       t2_reg, t2_next;
    logic [31:0]       r2_reg, r2_next;
    logic [32:0]       span_reg, span_next;
    logic              sp_neg_reg, sp_neg_next;
    logic [31:0]       mdt_reg, mdt_next;
    logic [32:0]       dr_reg, dr_next;
    logic              dr_neg_reg, dr_neg_next;
    logic [MUL_P_W-1:0] lo_reg, lo_next;
    logic [MUL_P_W-1:0] hi_reg, hi_next;
    logic [63:0]       num_reg, num_next;
    logic [31:0]       rem_reg, rem_next;
    logic [Q_W-1:0]    q_reg, q_next;

    logic [LW-1:0]     cnt_l;
    logic [LW-1:0]     n_l;
    logic              alu_ge;
    logic              tenor_eq;
    logic [32:0]       rem_sh;
    logic              neg;
    logic              res_fits;

    // table write straight from an accepted write item
    assign tbl_wr_en   = in_accept && (in_cmd == CMD_WRITE)
                         && (32'(in_entry_index) < 32'(MAX_ENTRIES));
    assign tbl_wr_addr = AW'(in_entry_index);
    assign tbl_wr_data = '{tenor: in_tenor, rate: in_rate};
    assign tbl_rd_addr = scan_addr_reg;

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // entries in use, clamped to MIN_ENTRIES..MAX_ENTRIES
    always_comb
    begin
        cnt_l = LW'(entry_count);
        if (cnt_l < LW'(MIN_ENTRIES))
        begin
            n_l = LW'(MIN_ENTRIES);
        end
        else if (cnt_l > LW'(MAX_ENTRIES))
        begin
            n_l = LW'(MAX_ENTRIES);
        end
        else
        begin
            n_l = cnt_l;
        end
    end

    assign alu_ge   = ~alu_sum[ALU_W-1];
    assign tenor_eq = (tbl_rd_data.tenor == t_reg);
    assign rem_sh   = {rem_reg, num_reg[k_reg]};
    assign neg      = sp_neg_reg ^ dr_neg_reg;
    assign res_fits = (&alu_sum[ALU_W-1:31]) || ~(|alu_sum[ALU_W-1:31]);

    // multiplier operands: low half of dt, then high half
    assign mul_a = dr_reg;
    assign mul_b = (state_reg == S_MUL_HI) ? mdt_reg[31:16] : mdt_reg[15:0];

    // next-state and datapath steps
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        scan_addr_next = scan_addr_reg;
        cmp_idx_next   = cmp_idx_reg;
        rd_vld_next    = rd_vld_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        t1_next        = t1_reg;
        r1_next        = r1_reg;
        t2_next        = t2_reg;
        r2_next        = r2_reg;
        span_next      = span_reg;
        sp_neg_next    = sp_neg_reg;
        mdt_next       = mdt_reg;
        dr_next        = dr_reg;
        dr_neg_next    = dr_neg_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        alu_req        = '{a: '0, b: '0, sub: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_cmd == CMD_QUERY)
                    begin
                        t_next         = in_query_time;
                        last_next      = AW'(n_l - LW'(1));
                        scan_addr_next = '0;
                        rd_vld_next    = 1'b0;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        res_next   = '{rate: '0, status: STAT_OK};
                        state_next = S_DONE;
                    end
                end
            end

            // one entry per cycle; the previous entry is kept as the lower point
            S_SCAN:
            begin
                alu_req = '{a: {{(ALU_W-32){1'b0}}, tbl_rd_data.tenor},
                            b: {{(ALU_W-32){1'b0}}, t_reg}, sub: 1'b1};
                if (scan_addr_reg != last_reg)
                begin
                    scan_addr_next = scan_addr_reg + AW'(1);
                end
                cmp_idx_next = scan_addr_reg;
                rd_vld_next  = 1'b1;
                if (rd_vld_reg)
                begin
                    if (tenor_eq)
                    begin
                        res_next   = '{rate: tbl_rd_data.rate, status: STAT_OK};
                        state_next = S_DONE;
                    end
                    else if (alu_ge && (cmp_idx_reg == '0))
                    begin
                        res_next   = '{rate: '0, status: STAT_BEFORE};
                        state_next = S_DONE;
                    end
                    else if (alu_ge || (cmp_idx_reg == last_reg))
                    begin
                        t2_next    = tbl_rd_data.tenor;
                        r2_next    = tbl_rd_data.rate;
                        state_next = S_SPAN;
                    end
                    else
                    begin
                        t1_next = tbl_rd_data.tenor;
                        r1_next = tbl_rd_data.rate;
                    end
                end
            end

            // span = t2 - t1
            S_SPAN:
            begin
                alu_req   = '{a: {{(ALU_W-32){1'b0}}, t2_reg},
                              b: {{(ALU_W-32){1'b0}}, t1_reg}, sub: 1'b1};
                span_next = alu_sum[32:0];
                if (alu_sum == '0)
                begin
                    res_next   = '{rate: '0, status: STAT_ZSPAN};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MSP;
                end
            end

            // |span|
            S_MSP:
            begin
                alu_req     = '{a: '0, b: {{(ALU_W-33){span_reg[32]}}, span_reg},
                                sub: span_reg[32]};
                span_next   = alu_sum[32:0];
                sp_neg_next = span_reg[32];
                state_next  = S_DT;
            end

            // dt = t - t1, always positive here
            S_DT:
            begin
                alu_req    = '{a: {{(ALU_W-32){1'b0}}, t_reg},
                               b: {{(ALU_W-32){1'b0}}, t1_reg}, sub: 1'b1};
                mdt_next   = alu_sum[31:0];
                state_next = S_DR;
            end

            // dr = r2 - r1
            S_DR:
            begin
                alu_req    = '{a: {{(ALU_W-32){r2_reg[31]}}, r2_reg},
                               b: {{(ALU_W-32){r1_reg[31]}}, r1_reg}, sub: 1'b1};
                dr_next    = alu_sum[32:0];
                state_next = S_MDR;
            end

            // |dr|
            S_MDR:
            begin
                alu_req     = '{a: '0, b: {{(ALU_W-33){dr_reg[32]}}, dr_reg},
                                sub: dr_reg[32]};
                dr_next     = alu_sum[32:0];
                dr_neg_next = dr_reg[32];
                state_next  = S_MUL_LO;
            end

            S_MUL_LO:
            begin
                lo_next    = mul_p;
                state_next = S_MUL_HI;
            end

            S_MUL_HI:
            begin
                hi_next    = mul_p;
                state_next = S_ACC;
            end

            // product = lo + hi * 2^16
            S_ACC:
            begin
                alu_req    = '{a: {{(ALU_W-MUL_P_W){1'b0}}, lo_reg},
                               b: {{(ALU_W-MUL_P_W-MUL_B_W){1'b0}}, hi_reg,
                                   {MUL_B_W{1'b0}}},
                               sub: 1'b0};
                num_next   = alu_sum[63:0];
                state_next = S_NUM;
            end

            // add half the span for rounding
            S_NUM:
            begin
                alu_req    = '{a: {{(ALU_W-64){1'b0}}, num_reg},
                               b: {{(ALU_W-31){1'b0}}, span_reg[31:1]}, sub: 1'b0};
                num_next   = alu_sum[63:0];
                state_next = S_OVF;
            end

            // quotient of 2^34 or more saturates in any case
            S_OVF:
            begin
                alu_req = '{a: {{(ALU_W-30){1'b0}}, num_reg[63:34]},
                            b: {{(ALU_W-32){1'b0}}, span_reg[31:0]}, sub: 1'b1};
                if (alu_ge)
                begin
                    q_next     = '1;
                    state_next = S_FIN;
                end
                else
                begin
                    rem_next   = {2'b00, num_reg[63:34]};
                    q_next     = '0;
                    k_next     = K_W'(Q_W - 1);
                    state_next = S_DIV;
                end
            end

            // restoring divide, one quotient bit per cycle
            S_DIV:
            begin
                alu_req = '{a: {{(ALU_W-33){1'b0}}, rem_sh},
                            b: {{(ALU_W-32){1'b0}}, span_reg[31:0]}, sub: 1'b1};
                if (alu_ge)
                begin
                    rem_next = alu_sum[31:0];
                    q_next   = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    q_next   = {q_reg[Q_W-2:0], 1'b0};
                end
                if (k_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    k_next = k_reg - K_W'(1);
                end
            end

            // r1 +/- q, then clamp
            S_FIN:
            begin
                alu_req = '{a: {{(ALU_W-32){r1_reg[31]}}, r1_reg},
                            b: {{(ALU_W-Q_W){1'b0}}, q_reg}, sub: neg};
                if (q_reg[Q_W-1] && (|q_reg[Q_W-2:0]))
                begin
                    res_next = '{rate: neg ? RATE_MIN : RATE_MAX, status: STAT_SAT};
                end
                else if (res_fits)
                begin
                    res_next = '{rate: alu_sum[31:0], status: STAT_OK};
                end
                else
                begin
                    res_next = '{rate: alu_sum[ALU_W-1] ? RATE_MIN : RATE_MAX,
                                 status: STAT_SAT};
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, counters and the registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= '{rate: '0, status: STAT_OK};
            scan_addr_reg <= '0;
            cmp_idx_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            last_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            scan_addr_reg <= scan_addr_next;
            cmp_idx_reg   <= cmp_idx_next;
            rd_vld_reg    <= rd_vld_next;
            last_reg      <= last_next;
            k_reg         <= k_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        t1_reg     <= t1_next;
        r1_reg     <= r1_next;
        t2_reg     <= t2_next;
        r2_reg     <= r2_next;
        span_reg   <= span_next;
        sp_neg_reg <= sp_neg_next;
        mdt_reg    <= mdt_next;
        dr_reg     <= dr_next;
        dr_neg_reg <= dr_neg_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
    end

endmodule

/* hdl/piecewise_linear_rate_interp.sv */
// Top level of the piecewise-linear rate interpolator: ports, config register, output stage.
//
// Input stream (s_axis_*): tuser selects a write (0) or a query (1). A write stores
// one breakpoint (tenor in seconds, rate in signed Q16.16); a query gives a time.
// Every request gives exactly one response on the output stream (m_axis_*): the
// rate in tdata and a status in tuser (ok, before first tenor, saturated, zero span).
// cfg_wr_en/cfg_wr_data set the number of entries in use; write it only while idle.
// A write goes straight to the response state. A query scans the table one entry per
// cycle up to the first tenor at or past the query time, then works on the shared adder:
// span, |span|, dt, dr, |dr|, two product halves and their sum, rounding term, overflow
// check, bit-per-cycle rounding divide for a 34-bit quotient, final add and clamp. Exact
// hits and times before the first tenor end with the scan, zero spans at the span step.
// One request is in work at a time; s_axis_tready is low from acceptance until the
// response has moved to the output register, so a new request can be taken while
// the previous response still waits there. If the receiver stalls, the response
// holds and the sequencer waits with its next one.
// Reset clears control state and sets the entry count to 2; table contents are
// undefined until written.
module piecewise_linear_rate_interp
    import plri_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,   // entry_count
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index[3:0], tenor_seconds[35:4], rate_value[67:36], query_time[99:68]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // cmd[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // rate_result[31:0]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser   // status[1:0]
);

    localparam int AW = $clog2(MAX_ENTRIES);

    logic [CFG_W-1:0]   entry_count_reg;
    logic               in_accept;
    logic               seq_idle;
    logic               res_valid;
    logic               res_take;
    result_t            seq_res;
    logic               out_valid_reg;
    result_t            out_reg;

    logic               tbl_wr_en;
    logic [AW-1:0]      tbl_wr_addr;
    entry_t             tbl_wr_data;
    logic [AW-1:0]      tbl_rd_addr;
    entry_t             tbl_rd_data;

    alu_req_t           alu_req;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [ALU_W-1:0]   alu_sum;
    logic [MUL_P_W-1:0] mul_p;

    assign s_axis_tready = seq_idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // entry count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= CNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    plri_tbl #(
        .DEPTH   (MAX_ENTRIES)
    ) u_tbl (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    plri_alu u_alu (
        .req   (alu_req),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .sum   (alu_sum),
        .prod  (mul_p)
    );

    plri_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_accept      (in_accept),
        .in_cmd         (s_axis_tuser[0]),
        .in_entry_index (s_axis_tdata[3:0]),
        .in_tenor       (s_axis_tdata[35:4]),
        .in_rate        (s_axis_tdata[67:36]),
        .in_query_time  (s_axis_tdata[99:68]),
        .entry_count    (entry_count_reg),
        .tbl_wr_en      (tbl_wr_en),
        .tbl_wr_addr    (tbl_wr_addr),
        .tbl_wr_data    (tbl_wr_data),
        .tbl_rd_addr    (tbl_rd_addr),
        .tbl_rd_data    (tbl_rd_data),
        .alu_req        (alu_req),
        .mul_a          (mul_a),
        .mul_b          (mul_b),
        .alu_sum        (alu_sum),
        .mul_p          (mul_p),
        .idle           (seq_idle),
        .res_valid      (res_valid),
        .res            (seq_res),
        .res_take       (res_take)
    );

    // output register: loads when empty or being drained
    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= seq_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.rate;
    assign m_axis_tuser  = out_reg.status;

endmodule

/* hdl/plri_chk.sv */
// Port-level checker for the rate interpolator, bound to the top level.
module plri_chk
    import plri_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted request");

    // stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled response changed");

    // error statuses carry a zero rate
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_BEFORE || m_axis_tuser == STAT_ZSPAN)
            |-> m_axis_tdata == '0)
        else $error("error status with nonzero rate");

    // saturated results sit on a bound
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_SAT
            |-> (m_axis_tdata == RATE_MAX || m_axis_tdata == RATE_MIN))
        else $error("saturated rate not at a bound");

endmodule

bind piecewise_linear_rate_interp plri_chk u_plri_chk (.*);

/* tb/piecewise_linear_rate_interp_test.sv */
// Self-checking testbench for the piecewise-linear rate interpolator: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module piecewise_linear_rate_interp_test
    import plri_pkg::*;
();

    localparam int ITEMS       = 1250;  // requests to send
    localparam int QUIET_TAIL  = 150;   // requests at the end sent with no idling
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int STALL_LIMIT = 3000;  // hold-off plus a full query, several times over
    localparam int TAIL_CYCLES = 100;   // longest query latency with margin

    // Expected responses and a private copy of the table and entry count
    class rate_scoreboard;
        logic [31:0]      tenor_tbl[DEF_MAX_ENTRIES];
        logic [31:0]      rate_tbl[DEF_MAX_ENTRIES];
        logic [CFG_W-1:0] count_reg;
        result_t          want_q[$];
        int unsigned      n_bad;
        int unsigned      n_checked;

        function new();
            count_reg = CNT_RESET;
            n_bad     = 0;
            n_checked = 0;
            foreach (tenor_tbl[k])
            begin
                tenor_tbl[k] = '0;
                rate_tbl[k]  = '0;
            end
        endfunction

        function void set_count(logic [CFG_W-1:0] v);
            count_reg = v;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        // Apply an accepted request and queue the response it must produce
        function void note_request(logic cmd, logic [3:0] idx, logic [31:0] ten,
                                   logic [31:0] rv, logic [31:0] tq);
            result_t     want;
            int unsigned n, i, lo, hi;
            longint      span, dt, dr, acc;
            bit [63:0]   mag_dr, mag_dt, mag_sp, quo;
            bit          neg;
            want.rate   = '0;
            want.status = STAT_OK;
            if (cmd == CMD_WRITE)
            begin
                tenor_tbl[idx] = ten;
                rate_tbl[idx]  = rv;
            end
            else if (tq < tenor_tbl[0])
                want.status = STAT_BEFORE;
            else
            begin
                n = (count_reg < MIN_ENTRIES) ? MIN_ENTRIES :
                    (count_reg > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : count_reg;
                // first entry in use at or past the query time
                i = 0;
                while (i < n && tenor_tbl[i] < tq)
                    i++;
                if (i < n && (tenor_tbl[i] == tq || i == 0))
                    want.rate = rate_tbl[i];
                else
                begin
                    // interpolate inside the table, extrapolate past its end
                    lo   = (i < n) ? i - 1 : n - 2;
                    hi   = (i < n) ? i : n - 1;
                    span = longint'(tenor_tbl[hi]) - longint'(tenor_tbl[lo]);
                    if (span == 0)
                        want.status = STAT_ZSPAN;
                    else
                    begin
                        dt     = longint'(tq) - longint'(tenor_tbl[lo]);
                        dr     = longint'($signed(rate_tbl[hi])) -
                                 longint'($signed(rate_tbl[lo]));
                        mag_dr = (dr < 0) ? -dr : dr;
                        mag_dt = (dt < 0) ? -dt : dt;
                        mag_sp = (span < 0) ? -span : span;
                        neg    = ((dr < 0) != (dt < 0)) != (span < 0);
                        // one rounding, half away from zero
                        quo    = (mag_dr * mag_dt + mag_sp / 2) / mag_sp;
                        if (quo > 64'h2_0000_0000)
                            acc = neg ? -64'sd2147483649 : 64'sd2147483648;
                        else
                            acc = longint'($signed(rate_tbl[lo])) +
                                  (neg ? -longint'(quo) : longint'(quo));
                        if (acc > 64'sd2147483647)
                        begin
                            want.rate   = RATE_MAX;
                            want.status = STAT_SAT;
                        end
                        else if (acc < -64'sd2147483648)
                        begin
                            want.rate   = RATE_MIN;
                            want.status = STAT_SAT;
                        end
                        else
                            want.rate = acc[31:0];
                    end
                end
            end
            want_q = {want_q, want};
        endfunction

        // Compare one accepted response with the oldest expectation
        function void check_result(logic [31:0] rate, logic [1:0] st);
            result_t want;
            if (want_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: response with nothing expected: rate=%h status=%0d",
                             rate, st);
                return;
            end
            want = want_q.pop_front();
            if (rate !== want.rate || st !== want.status)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display({"ERROR: response %0d: expected rate=%h status=%0d, ",
                              "got rate=%h status=%0d"},
                             n_checked, want.rate, want.status, rate, st);
            end
            n_checked++;
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    rate_scoreboard sb;
    int unsigned    n_sent;
    bit             quiet;     // no idling on either side
    bit             hold_off;  // receiver holds off for HOLD_CYCLES

    piecewise_linear_rate_interp i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one request, with an optional idle burst first; returns at the accepting edge
    task automatic send_request(input logic cmd, input logic [3:0] idx,
                                input logic [31:0] ten, input logic [31:0] rv,
                                input logic [31:0] tq);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, tq, rv, ten, idx};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(cmd, idx, ten, rv, tq);
        n_sent++;
    endtask

    // Unused fields carry random bits
    task automatic write_entry(input logic [3:0] idx, input logic [31:0] ten,
                               input logic [31:0] rv);
        send_request(CMD_WRITE, idx, ten, rv, $urandom);
    endtask

    task automatic ask_rate(input logic [31:0] tq);
        send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, tq);
    endtask

    // Drain every response, then write the entry count while the block is idle
    task automatic write_count(input logic [CFG_W-1:0] v);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.set_count(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Fill entries 0..n-1; mostly increasing tenors, some duplicates, disorder, extremes
    task automatic load_table(input int n);
        int unsigned style;
        logic [31:0] ten, rv;
        style = $urandom_range(0, 9);
        ten   = (style == 9) ? $urandom_range(0, 32'h0000_1000) : $urandom_range(0, 100000);
        rv    = $urandom_range(0, 32'h000A_0000);
        for (int k = 0; k < n; k++)
        begin
            write_entry(4'(k), ten, rv);
            case (style)
                6:       ten = ($urandom_range(0, 2) == 0) ? ten : ten + $urandom_range(1, 5000);
                7:       ten = $urandom;
                9:       ten = ten + $urandom_range(1, 32'h0FFF_FFFF);
                default: ten = ten + $urandom_range(1, 5000);
            endcase
            case (style)
                8:       rv = ($urandom_range(0, 2) == 0) ? $urandom :
                              ($urandom_range(0, 1) == 0) ? RATE_MAX : RATE_MIN;
                9:       rv = $urandom;
                default: rv = rv + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            endcase
        end
    endtask

    // Query time aimed at hits, gaps, both ends of the table and plain noise
    function automatic logic [31:0] pick_time(input int n);
        int unsigned k;
        logic [31:0] lo_t, hi_t, last_t;
        k      = $urandom_range(0, n - 1);
        lo_t   = sb.tenor_tbl[k];
        hi_t   = (k + 1 < n) ? sb.tenor_tbl[k + 1] : lo_t;
        last_t = sb.tenor_tbl[n - 1];
        case ($urandom_range(0, 7))
            0:       return lo_t;
            1, 2:    return (hi_t > lo_t) ? lo_t + $urandom_range(1, hi_t - lo_t) : lo_t + 1;
            3:       return (last_t == '1) ? last_t : last_t + $urandom_range(1, ~last_t);
            4:       return last_t + $urandom_range(1, 2000);
            5:       return (sb.tenor_tbl[0] == 0) ? 32'd0 :
                            $urandom_range(0, sb.tenor_tbl[0] - 1);
            6:       return $urandom;
            default:
                case ($urandom_range(0, 3))
                    0:       return 32'd0;
                    1:       return 32'hFFFF_FFFF;
                    2:       return lo_t - 1;
                    default: return lo_t + 1;
                endcase
        endcase
    endfunction

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Response monitor
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);

    // Watchdog: ends the run when nothing moves for too long
    initial
    begin
        int unsigned still_cycles;
        still_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                still_cycles = 0;
            else
                still_cycles++;
            if (still_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no request or response accepted for %0d cycles", STALL_LIMIT);
                $display("** piecewise_linear_rate_interp: FAILED **");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        logic [CFG_W-1:0] count_plan[8];
        logic [CFG_W-1:0] cnt;
        logic [31:0]      rv;
        int               n_use, n_q, phase;
        sb            = new();
        n_sent        = 0;
        quiet         = 1'b0;
        hold_off      = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        count_plan    = '{5'd2, 5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd9, 5'd3};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: full table with rounding ties, extreme rates and a duplicate last tenor
        write_count(5'd16);
        for (int k = 0; k < DEF_MAX_ENTRIES; k++)
        begin
            case (k)
                0, 2, 14: rv = RATE_MIN;
                1:        rv = RATE_MIN + 1;
                13, 15:   rv = RATE_MAX;
                default:  rv = (k % 2) ? -(k << 16) : (k << 16);
            endcase
            write_entry(4'(k), (k == 15) ? 32'd1500 : 32'(100 * (k + 1)), rv);
        end
        ask_rate(32'd0);            // before first tenor
        ask_rate(32'd100);          // exact hit on the first entry
        ask_rate(32'd150);          // tie, rounds up
        ask_rate(32'd250);          // tie, rounds down
        ask_rate(32'd777);
        ask_rate(32'd1500);         // exact hit
        ask_rate(32'd1501);         // past the end, zero span
        ask_rate(32'hFFFF_FFFF);
        write_entry(4'd15, 32'd1600, RATE_MAX);
        ask_rate(32'hFFFF_FFFF);    // steep extrapolation, saturates
        ask_rate(32'd1550);

        // Random phases, each with its own entry count and table
        phase = 0;
        while (n_sent < ITEMS)
        begin
            cnt = (phase < 8) ? count_plan[phase] : 5'($urandom_range(0, 31));
            write_count(cnt);
            n_use    = (cnt < MIN_ENTRIES) ? MIN_ENTRIES :
                       (cnt > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : cnt;
            quiet    = (n_sent + QUIET_TAIL >= ITEMS) || ($urandom_range(0, 4) == 0);
            hold_off = (phase == 3);
            load_table(n_use);
            n_q = $urandom_range(20, 60);
            repeat (n_q)
            begin
                // occasional rewrite of any entry keeps the table from staying tidy
                if ($urandom_range(0, 14) == 0)
                    write_entry(4'($urandom_range(0, 15)), $urandom, $urandom);
                else
                    ask_rate(pick_time(n_use));
            end
            phase++;
        end

        // Drain and let any stray response show up
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            $display("ERROR: %0d responses never arrived", sb.pending());
        if (sb.n_bad == 0 && sb.pending() == 0)
            $display("** piecewise_linear_rate_interp: PASSED **");
        else
            $display("** piecewise_linear_rate_interp: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
hdl/plri_pkg.sv
hdl/plri_tbl.sv
hdl/plri_alu.sv
hdl/plri_seq.sv
hdl/piecewise_linear_rate_interp.sv
hdl/plri_chk.sv
tb/piecewise_linear_rate_interp_test.sv
